[rtl/cpd_pkg.sv]
// Shared constants, angle table and types for the cartesian to polar unit.
package cpd_pkg;

	// Extra fraction bits carried on the rotated coordinates.
	localparam int GUARD_BITS = 8;
	// Fraction bits of the angle accumulator and of the angle result.
	localparam int ANGLE_FRAC = 20;
	localparam int OUT_FRAC = 7;
	localparam int ROUND_SHIFT = ANGLE_FRAC - OUT_FRAC;

	localparam int ATAN_ENTRIES = 24;
	localparam int Z_WIDTH = 28;
	localparam int FULL_WIDTH = 29;
	localparam int OUT_WIDTH = 16;
	localparam int FULL_TURN_OUT = 46080;

	typedef logic signed [Z_WIDTH-1:0] angle_acc_t;
	typedef logic [FULL_WIDTH-1:0] angle_full_t;

	// atan(2^-i) in degrees scaled by 2^20, rounded to nearest.
	localparam logic [Z_WIDTH-1:0] ATAN_DEG [ATAN_ENTRIES] = '{
		28'd47185920, 28'd27855475, 28'd14718068, 28'd7471121,
		28'd3750058, 28'd1876857, 28'd938658, 28'd469357,
		28'd234682, 28'd117342, 28'd58671, 28'd29335,
		28'd14668, 28'd7334, 28'd3667, 28'd1833,
		28'd917, 28'd458, 28'd229, 28'd115,
		28'd57, 28'd29, 28'd14, 28'd7
	};

	localparam angle_acc_t QUARTER_TURN = angle_acc_t'(90) <<< ANGLE_FRAC;
	localparam angle_full_t HALF_TURN = angle_full_t'(180) << ANGLE_FRAC;
	localparam angle_full_t ROUND_HALF = angle_full_t'(1) << (ROUND_SHIFT - 1);

	// Quadrant information that rides along with each transaction.
	typedef struct packed {
		logic x_neg;
		logic y_neg;
		logic origin;
	} quad_t;

endpackage

[rtl/cpd_prep.sv]
// Input stages: absolute values, quadrant flags, squares and their sum.
module cpd_prep #(
	parameter int COORD_WIDTH = 16
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          in_valid,
	output logic                          in_ready,
	input  logic signed [COORD_WIDTH-1:0] coord_x,
	input  logic signed [COORD_WIDTH-1:0] coord_y,
	output logic                          out_valid,
	input  logic                          out_ready,
	output cpd_pkg::quad_t                out_quad,
	output logic [COORD_WIDTH-1:0]        out_ax,
	output logic [COORD_WIDTH-1:0]        out_ay,
	output logic [2*COORD_WIDTH-1:0]      out_sum
);

	localparam int W = COORD_WIDTH;
	localparam int SW = 2 * COORD_WIDTH;

	logic signed [SW-1:0] prod_x, prod_y;
	logic [W-1:0] abs_x, abs_y;

	logic valid_s1, valid_s2, ready_s1, ready_s2;
	logic [SW-1:0] sqx_s1, sqy_s1, sum_s2;
	logic [W-1:0] ax_s1, ay_s1, ax_s2, ay_s2;
	cpd_pkg::quad_t quad_s1, quad_s2;

	// A signed square equals the square of the magnitude, so no abs is needed here.
	assign prod_x = coord_x * coord_x;
	assign prod_y = coord_y * coord_y;
	assign abs_x = coord_x[W-1] ? W'(-coord_x) : W'(coord_x);
	assign abs_y = coord_y[W-1] ? W'(-coord_y) : W'(coord_y);

	assign ready_s1 = !valid_s1 || ready_s2;
	assign ready_s2 = !valid_s2 || out_ready;
	assign in_ready = ready_s1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
			valid_s2 <= 1'b0;
		end else begin
			if (ready_s1) begin
				valid_s1 <= in_valid;
			end
			if (ready_s2) begin
				valid_s2 <= valid_s1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (in_valid && ready_s1) begin
			sqx_s1 <= prod_x;
			sqy_s1 <= prod_y;
			ax_s1 <= abs_x;
			ay_s1 <= abs_y;
			quad_s1.x_neg <= coord_x[W-1];
			quad_s1.y_neg <= coord_y[W-1];
			quad_s1.origin <= (coord_x == '0) && (coord_y == '0);
		end
		if (valid_s1 && ready_s2) begin
			sum_s2 <= sqx_s1 + sqy_s1;
			ax_s2 <= ax_s1;
			ay_s2 <= ay_s1;
			quad_s2 <= quad_s1;
		end
	end

	assign out_valid = valid_s2;
	assign out_quad = quad_s2;
	assign out_ax = ax_s2;
	assign out_ay = ay_s2;
	assign out_sum = sum_s2;

endmodule

[rtl/cpd_cell.sv]
// One cell of the chain: a vectoring rotation step and one square root digit.
module cpd_cell #(
	parameter int IDX = 0,
	parameter int ITERATIONS = 16,
	parameter int COORD_WIDTH = 16
) (
	input  logic                                               clk,
	input  logic                                               arst_n,
	input  logic                                               in_valid,
	output logic                                               in_ready,
	input  cpd_pkg::quad_t                                     in_quad,
	input  logic signed [COORD_WIDTH+cpd_pkg::GUARD_BITS+2:0]  in_cx,
	input  logic signed [COORD_WIDTH+cpd_pkg::GUARD_BITS+2:0]  in_cy,
	input  cpd_pkg::angle_acc_t                                in_z,
	input  logic [2*COORD_WIDTH-1:0]                           in_rem,
	input  logic [2*COORD_WIDTH-1:0]                           in_root,
	output logic                                               out_valid,
	input  logic                                               out_ready,
	output cpd_pkg::quad_t                                     out_quad,
	output logic signed [COORD_WIDTH+cpd_pkg::GUARD_BITS+2:0]  out_cx,
	output logic signed [COORD_WIDTH+cpd_pkg::GUARD_BITS+2:0]  out_cy,
	output cpd_pkg::angle_acc_t                                out_z,
	output logic [2*COORD_WIDTH-1:0]                           out_rem,
	output logic [2*COORD_WIDTH-1:0]                           out_root
);

	localparam int W = COORD_WIDTH;
	localparam int SW = 2 * COORD_WIDTH;
	localparam int CW = COORD_WIDTH + cpd_pkg::GUARD_BITS + 3;
	localparam bit DO_ROT = (IDX < ITERATIONS) && (IDX < cpd_pkg::ATAN_ENTRIES);
	localparam bit DO_SQ = IDX < W;

	logic signed [CW-1:0] cx_n, cy_n;
	cpd_pkg::angle_acc_t z_n;
	logic [SW-1:0] rem_n, root_n;

	logic valid_q;
	cpd_pkg::quad_t quad_q;
	logic signed [CW-1:0] cx_q, cy_q;
	cpd_pkg::angle_acc_t z_q;
	logic [SW-1:0] rem_q, root_q;

	generate
		if (DO_ROT) begin : g_rot
			logic signed [CW-1:0] dx, dy;
			cpd_pkg::angle_acc_t step;

			// Arithmetic shifts round toward minus infinity.
			assign dx = in_cy >>> IDX;
			assign dy = in_cx >>> IDX;
			assign step = cpd_pkg::angle_acc_t'(cpd_pkg::ATAN_DEG[IDX]);
			assign cx_n = in_cy[CW-1] ? in_cx - dx : in_cx + dx;
			assign cy_n = in_cy[CW-1] ? in_cy + dy : in_cy - dy;
			assign z_n = in_cy[CW-1] ? in_z - step : in_z + step;
		end else begin : g_rot_pass
			assign cx_n = in_cx;
			assign cy_n = in_cy;
			assign z_n = in_z;
		end

		if (DO_SQ) begin : g_sq
			localparam logic [SW-1:0] BIT = {{(SW-1){1'b0}}, 1'b1} << (2 * (W - 1 - IDX));
			logic [SW:0] trial;
			logic take;

			assign trial = {1'b0, in_root} + {1'b0, BIT};
			assign take = {1'b0, in_rem} >= trial;
			assign rem_n = take ? in_rem - trial[SW-1:0] : in_rem;
			assign root_n = take ? (in_root >> 1) + BIT : in_root >> 1;
		end else begin : g_sq_pass
			assign rem_n = in_rem;
			assign root_n = in_root;
		end
	endgenerate

	assign in_ready = !valid_q || out_ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
		end else if (in_ready) begin
			valid_q <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (in_valid && in_ready) begin
			quad_q <= in_quad;
			cx_q <= cx_n;
			cy_q <= cy_n;
			z_q <= z_n;
			rem_q <= rem_n;
			root_q <= root_n;
		end
	end

	assign out_valid = valid_q;
	assign out_quad = quad_q;
	assign out_cx = cx_q;
	assign out_cy = cy_q;
	assign out_z = z_q;
	assign out_rem = rem_q;
	assign out_root = root_q;

endmodule

[rtl/cpd_post.sv]
// Output stages: angle clamp and quadrant fold, rounding, radius rounding.
module cpd_post #(
	parameter int COORD_WIDTH = 16
) (
	input  logic                                clk,
	input  logic                                arst_n,
	input  logic                                in_valid,
	output logic                                in_ready,
	input  cpd_pkg::quad_t                      in_quad,
	input  cpd_pkg::angle_acc_t                 in_z,
	input  logic [2*COORD_WIDTH-1:0]            in_rem,
	input  logic [2*COORD_WIDTH-1:0]            in_root,
	output logic                                out_valid,
	input  logic                                out_ready,
	output logic [cpd_pkg::OUT_WIDTH-1:0]       radius,
	output logic [cpd_pkg::OUT_WIDTH-1:0]       angle
);

	localparam int SW = 2 * COORD_WIDTH;

	cpd_pkg::angle_acc_t z_clamp;
	cpd_pkg::angle_full_t phi, full_n, rounded;
	logic [SW-1:0] root_rnd;
	logic [cpd_pkg::OUT_WIDTH-1:0] turns;

	logic valid_s1, valid_s2, ready_s1, ready_s2;
	cpd_pkg::angle_full_t full_s1;
	logic [cpd_pkg::OUT_WIDTH-1:0] radius_s1, radius_s2, angle_s2;

	always_comb begin
		if (in_z[cpd_pkg::Z_WIDTH-1]) begin
			z_clamp = '0;
		end else if (in_z > cpd_pkg::QUARTER_TURN) begin
			z_clamp = cpd_pkg::QUARTER_TURN;
		end else begin
			z_clamp = in_z;
		end
	end

	assign phi = cpd_pkg::angle_full_t'(unsigned'(z_clamp));

	always_comb begin
		if (in_quad.origin) begin
			full_n = '0;
		end else if (!in_quad.x_neg && !in_quad.y_neg) begin
			full_n = phi;
		end else if (in_quad.x_neg && !in_quad.y_neg) begin
			full_n = cpd_pkg::HALF_TURN - phi;
		end else if (in_quad.x_neg) begin
			full_n = cpd_pkg::HALF_TURN + phi;
		end else begin
			full_n = (cpd_pkg::HALF_TURN << 1) - phi;
		end
	end

	// The remainder exceeds the root exactly when the true root lies above root + 1/2.
	assign root_rnd = in_root + SW'(in_rem > in_root);

	assign rounded = full_s1 + cpd_pkg::ROUND_HALF;
	assign turns = rounded[cpd_pkg::FULL_WIDTH-1:cpd_pkg::ROUND_SHIFT];

	assign ready_s1 = !valid_s1 || ready_s2;
	assign ready_s2 = !valid_s2 || out_ready;
	assign in_ready = ready_s1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
			valid_s2 <= 1'b0;
		end else begin
			if (ready_s1) begin
				valid_s1 <= in_valid;
			end
			if (ready_s2) begin
				valid_s2 <= valid_s1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (in_valid && ready_s1) begin
			full_s1 <= full_n;
			radius_s1 <= root_rnd[cpd_pkg::OUT_WIDTH-1:0];
		end
		if (valid_s1 && ready_s2) begin
			radius_s2 <= radius_s1;
			if (turns >= cpd_pkg::OUT_WIDTH'(cpd_pkg::FULL_TURN_OUT)) begin
				angle_s2 <= turns - cpd_pkg::OUT_WIDTH'(cpd_pkg::FULL_TURN_OUT);
			end else begin
				angle_s2 <= turns;
			end
		end
	end

	assign out_valid = valid_s2;
	assign radius = radius_s2;
	assign angle = angle_s2;

endmodule

[rtl/cartesian_to_polar_degrees_unit.sv]
// Cartesian to polar conversion unit, angle in degrees (top level).
//
// Usage: a point (coord_x, coord_y) enters on the point channel, a transaction
// completing at a rising edge with point_valid high and point_stall low. One
// result (radius, angle) leaves on the polar channel per point, in order, a
// transaction completing with polar_valid high and polar_stall low.
// radius is round(sqrt(x^2 + y^2)); angle is in 1/128 degree, 0 to under 360.
// Two input stages (squares, sum), one chain cell per rotation step or root
// digit, and two output stages (quadrant fold, rounding) form the pipeline.
// One point enters per cycle while point_stall is low. Every stage is
// elastic: it takes new data whenever it is empty or its successor takes
// its contents, so bubbles close up and points keep entering while a
// result waits at the output.
// point_stall rises only once every stage holds a point and polar_stall is high.
// Reset empties all stages; no point is held across reset.
module cartesian_to_polar_degrees_unit #(
	parameter int ITERATIONS = 16,
	parameter int COORD_WIDTH = 16
) (
	input  logic                                clk,
	input  logic                                arst_n,
	input  logic                                point_valid,
	output logic                                point_stall,
	input  logic signed [COORD_WIDTH-1:0]       coord_x,
	input  logic signed [COORD_WIDTH-1:0]       coord_y,
	output logic                                polar_valid,
	input  logic                                polar_stall,
	output logic [cpd_pkg::OUT_WIDTH-1:0]       radius,
	output logic [cpd_pkg::OUT_WIDTH-1:0]       angle
);

	localparam int SW = 2 * COORD_WIDTH;
	localparam int CW = COORD_WIDTH + cpd_pkg::GUARD_BITS + 3;
	localparam int NCELL = (ITERATIONS > COORD_WIDTH) ? ITERATIONS : COORD_WIDTH;

	logic prep_ready;
	logic [COORD_WIDTH-1:0] ax, ay;
	logic [SW-1:0] sum;

	logic valid_w [NCELL+1];
	logic ready_w [NCELL+1];
	cpd_pkg::quad_t quad_w [NCELL+1];
	logic signed [CW-1:0] cx_w [NCELL+1];
	logic signed [CW-1:0] cy_w [NCELL+1];
	cpd_pkg::angle_acc_t z_w [NCELL+1];
	logic [SW-1:0] rem_w [NCELL+1];
	logic [SW-1:0] root_w [NCELL+1];

	cpd_prep #(
		.COORD_WIDTH(COORD_WIDTH)
	) u_prep (
		.clk(clk),
		.arst_n(arst_n),
		.in_valid(point_valid),
		.in_ready(prep_ready),
		.coord_x(coord_x),
		.coord_y(coord_y),
		.out_valid(valid_w[0]),
		.out_ready(ready_w[0]),
		.out_quad(quad_w[0]),
		.out_ax(ax),
		.out_ay(ay),
		.out_sum(sum)
	);

	assign point_stall = !prep_ready;

	// The rotation starts from the magnitudes with guard bits below the point.
	assign cx_w[0] = {{(CW-COORD_WIDTH-cpd_pkg::GUARD_BITS){1'b0}}, ax,
		{cpd_pkg::GUARD_BITS{1'b0}}};
	assign cy_w[0] = {{(CW-COORD_WIDTH-cpd_pkg::GUARD_BITS){1'b0}}, ay,
		{cpd_pkg::GUARD_BITS{1'b0}}};
	assign z_w[0] = '0;
	assign rem_w[0] = sum;
	assign root_w[0] = '0;

	genvar k;
	generate
		for (k = 0; k < NCELL; k++) begin : g_chain
			cpd_cell #(
				.IDX(k),
				.ITERATIONS(ITERATIONS),
				.COORD_WIDTH(COORD_WIDTH)
			) u_cell (
				.clk(clk),
				.arst_n(arst_n),
				.in_valid(valid_w[k]),
				.in_ready(ready_w[k]),
				.in_quad(quad_w[k]),
				.in_cx(cx_w[k]),
				.in_cy(cy_w[k]),
				.in_z(z_w[k]),
				.in_rem(rem_w[k]),
				.in_root(root_w[k]),
				.out_valid(valid_w[k+1]),
				.out_ready(ready_w[k+1]),
				.out_quad(quad_w[k+1]),
				.out_cx(cx_w[k+1]),
				.out_cy(cy_w[k+1]),
				.out_z(z_w[k+1]),
				.out_rem(rem_w[k+1]),
				.out_root(root_w[k+1])
			);
		end
	endgenerate

	cpd_post #(
		.COORD_WIDTH(COORD_WIDTH)
	) u_post (
		.clk(clk),
		.arst_n(arst_n),
		.in_valid(valid_w[NCELL]),
		.in_ready(ready_w[NCELL]),
		.in_quad(quad_w[NCELL]),
		.in_z(z_w[NCELL]),
		.in_rem(rem_w[NCELL]),
		.in_root(root_w[NCELL]),
		.out_valid(polar_valid),
		.out_ready(!polar_stall),
		.radius(radius),
		.angle(angle)
	);

	// The folded and rounded angle always lies below a full turn.
	a_angle_range: assert property (@(posedge clk) disable iff (!arst_n)
		polar_valid |-> angle < cpd_pkg::OUT_WIDTH'(cpd_pkg::FULL_TURN_OUT))
		else $error("angle result reached a full turn");

	// With an empty output stage every stage can move, so the input must not stall.
	a_no_stall_when_empty: assert property (@(posedge clk) disable iff (!arst_n)
		!polar_valid |-> !point_stall)
		else $error("input stalled while the output stage was empty");

	// A zero radius only comes from the origin, whose angle is zero.
	a_origin_angle: assert property (@(posedge clk) disable iff (!arst_n)
		polar_valid && radius == '0 && COORD_WIDTH <= 16 |-> angle == '0)
		else $error("nonzero angle with zero radius");

endmodule

[tb/tb_top.sv]
// Testbench for the cartesian to polar unit: directed and random points against a predictor.
`timescale 1ns / 100ps

module tb_top;

	localparam int ITERATIONS = 16;
	localparam int COORD_WIDTH = 16;
	localparam int RANDOM_POINTS = 600;
	localparam int QUIET_TAIL = 80;
	localparam int LONG_HOLD = 100;
	localparam int HOLD_AT = 150;
	localparam int DRAIN_CYCLES = 40;

	typedef struct {
		logic signed [COORD_WIDTH-1:0] x;
		logic signed [COORD_WIDTH-1:0] y;
		logic [cpd_pkg::OUT_WIDTH-1:0] radius;
		logic [cpd_pkg::OUT_WIDTH-1:0] angle;
	} polar_expect_t;

	typedef struct {
		logic signed [COORD_WIDTH-1:0] x;
		logic signed [COORD_WIDTH-1:0] y;
		bit typed;
		logic [cpd_pkg::OUT_WIDTH-1:0] radius;
		logic [cpd_pkg::OUT_WIDTH-1:0] angle;
	} point_row_t;

	logic clk = 1'b0;
	logic arst_n;
	logic point_valid;
	logic point_stall;
	logic signed [COORD_WIDTH-1:0] coord_x;
	logic signed [COORD_WIDTH-1:0] coord_y;
	logic polar_valid;
	logic polar_stall;
	logic [cpd_pkg::OUT_WIDTH-1:0] radius;
	logic [cpd_pkg::OUT_WIDTH-1:0] angle;

	polar_expect_t pending_polar[$];
	int mismatches = 0;
	bit quiet_phase = 1'b0;
	bit long_hold_due = 1'b0;

	cartesian_to_polar_degrees_unit #(
		.ITERATIONS(ITERATIONS),
		.COORD_WIDTH(COORD_WIDTH)
	) u_top (
		.clk(clk),
		.arst_n(arst_n),
		.point_valid(point_valid),
		.point_stall(point_stall),
		.coord_x(coord_x),
		.coord_y(coord_y),
		.polar_valid(polar_valid),
		.polar_stall(polar_stall),
		.radius(radius),
		.angle(angle)
	);

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	// Rounded integer square root of x^2 + y^2 and the CORDIC angle folded into [0, 360).
	function automatic void predict_polar(input logic signed [COORD_WIDTH-1:0] x,
			input logic signed [COORD_WIDTH-1:0] y,
			output logic [cpd_pkg::OUT_WIDTH-1:0] rad,
			output logic [cpd_pkg::OUT_WIDTH-1:0] ang);
		longint sx, sy, ax, ay, cx, cy, dx, dy, z, full;
		longint unsigned sum, root, rem, probe, turn;
		sx = longint'(x);
		sy = longint'(y);
		ax = (sx < 0) ? -sx : sx;
		ay = (sy < 0) ? -sy : sy;

		sum = longint'(ax * ax + ay * ay);
		root = 0;
		rem = sum;
		probe = 64'd1 << 62;
		while (probe > rem)
			probe = probe >> 2;
		while (probe != 0) begin
			if (rem >= root + probe) begin
				rem = rem - (root + probe);
				root = (root >> 1) + probe;
			end else begin
				root = root >> 1;
			end
			probe = probe >> 2;
		end
		if (rem > root)
			root = root + 1;
		rad = root[cpd_pkg::OUT_WIDTH-1:0];

		if (sx == 0 && sy == 0) begin
			full = 0;
		end else begin
			// Arithmetic shifts of signed values floor, as the datapath does.
			cx = ax <<< cpd_pkg::GUARD_BITS;
			cy = ay <<< cpd_pkg::GUARD_BITS;
			z = 0;
			for (int i = 0; i < ITERATIONS && i < cpd_pkg::ATAN_ENTRIES; i++) begin
				dx = cy >>> i;
				dy = cx >>> i;
				if (cy >= 0) begin
					cx = cx + dx;
					cy = cy - dy;
					z = z + longint'(cpd_pkg::ATAN_DEG[i]);
				end else begin
					cx = cx - dx;
					cy = cy + dy;
					z = z - longint'(cpd_pkg::ATAN_DEG[i]);
				end
			end
			if (z < 0)
				z = 0;
			if (z > (longint'(90) << cpd_pkg::ANGLE_FRAC))
				z = longint'(90) << cpd_pkg::ANGLE_FRAC;
			if (sx >= 0 && sy >= 0)
				full = z;
			else if (sx < 0 && sy >= 0)
				full = (longint'(180) << cpd_pkg::ANGLE_FRAC) - z;
			else if (sx < 0)
				full = (longint'(180) << cpd_pkg::ANGLE_FRAC) + z;
			else
				full = (longint'(360) << cpd_pkg::ANGLE_FRAC) - z;
		end
		turn = (longint'(full) + (longint'(1) << (cpd_pkg::ROUND_SHIFT - 1)))
			>> cpd_pkg::ROUND_SHIFT;
		if (turn >= cpd_pkg::FULL_TURN_OUT)
			turn = turn - cpd_pkg::FULL_TURN_OUT;
		ang = turn[cpd_pkg::OUT_WIDTH-1:0];
	endfunction

	task automatic report_mismatch(input string what, input int got, input int want,
			input logic signed [COORD_WIDTH-1:0] x, input logic signed [COORD_WIDTH-1:0] y);
		$display("MISMATCH %s for point (%0d, %0d): got %0d, expected %0d",
			what, x, y, got, want);
		mismatches++;
	endtask

	// Offers one point and waits until the transaction completes; the caller stands at a falling edge.
	task automatic send_point(input logic signed [COORD_WIDTH-1:0] x,
			input logic signed [COORD_WIDTH-1:0] y, input bit typed,
			input logic [cpd_pkg::OUT_WIDTH-1:0] want_radius,
			input logic [cpd_pkg::OUT_WIDTH-1:0] want_angle);
		polar_expect_t item;
		if (!quiet_phase && $urandom_range(0, 5) == 0) begin
			point_valid = 1'b0;
			repeat ($urandom_range(1, 16)) @(negedge clk);
		end
		point_valid = 1'b1;
		coord_x = x;
		coord_y = y;
		@(posedge clk);
		while (point_stall)
			@(posedge clk);
		item.x = x;
		item.y = y;
		if (typed) begin
			item.radius = want_radius;
			item.angle = want_angle;
		end else begin
			predict_polar(x, y, item.radius, item.angle);
		end
		pending_polar.push_back(item);
		@(negedge clk);
	endtask

	function automatic logic signed [COORD_WIDTH-1:0] random_coord(input int mode);
		logic signed [COORD_WIDTH-1:0] v;
		case (mode)
			0: begin
				v = COORD_WIDTH'($urandom_range(0, 32)) - COORD_WIDTH'(16);
			end
			1: begin
				v = COORD_WIDTH'($urandom_range(0, 6)) - COORD_WIDTH'(3);
			end
			default: begin
				v = COORD_WIDTH'($urandom());
			end
		endcase
		return v;
	endfunction

	always @(posedge clk) begin
		polar_expect_t want;
		if (arst_n && polar_valid && !polar_stall) begin
			if (pending_polar.size() == 0) begin
				report_mismatch("unexpected result radius", radius, -1, 'x, 'x);
			end else begin
				want = pending_polar.pop_front();
				if (radius !== want.radius)
					report_mismatch("radius", radius, want.radius, want.x, want.y);
				if (angle !== want.angle)
					report_mismatch("angle", angle, want.angle, want.x, want.y);
			end
		end
	end

	// Receiver: random stall bursts, plus one long hold-off that backs the pipeline up.
	initial begin
		polar_stall = 1'b0;
		@(posedge arst_n);
		@(negedge clk);
		forever begin
			if (long_hold_due) begin
				long_hold_due = 1'b0;
				polar_stall = 1'b1;
				repeat (LONG_HOLD) @(negedge clk);
			end else if (!quiet_phase && $urandom_range(0, 5) == 0) begin
				polar_stall = 1'b1;
				repeat ($urandom_range(1, 16)) @(negedge clk);
			end else begin
				polar_stall = 1'b0;
				@(negedge clk);
			end
		end
	end

	initial begin
		#2_000_000;
		$display("Verification failed");
		$finish;
	end

	initial begin
		point_row_t directed[$];
		logic signed [COORD_WIDTH-1:0] rx;
		logic signed [COORD_WIDTH-1:0] ry;
		int mode;

		arst_n = 1'b0;
		point_valid = 1'b0;
		coord_x = '0;
		coord_y = '0;

		// The origin rows are the only ones whose answer is plain; the rest go through the predictor.
		directed = '{
			'{16'sd0, 16'sd0, 1'b1, 16'd0, 16'd0},
			'{16'sd1, 16'sd0, 1'b0, 16'd0, 16'd0},
			'{16'sd0, 16'sd1, 1'b0, 16'd0, 16'd0},
			'{-16'sd1, 16'sd0, 1'b0, 16'd0, 16'd0},
			'{16'sd0, -16'sd1, 1'b0, 16'd0, 16'd0},
			'{16'sd32767, 16'sd0, 1'b0, 16'd0, 16'd0},
			'{-16'sd32768, 16'sd0, 1'b0, 16'd0, 16'd0},
			'{16'sd0, 16'sd32767, 1'b0, 16'd0, 16'd0},
			'{16'sd0, -16'sd32768, 1'b0, 16'd0, 16'd0},
			'{16'sd32767, 16'sd32767, 1'b0, 16'd0, 16'd0},
			'{-16'sd32768, 16'sd32767, 1'b0, 16'd0, 16'd0},
			'{-16'sd32768, -16'sd32768, 1'b0, 16'd0, 16'd0},
			'{16'sd32767, -16'sd32768, 1'b0, 16'd0, 16'd0},
			'{16'sd1, 16'sd1, 1'b0, 16'd0, 16'd0},
			'{-16'sd1, 16'sd1, 1'b0, 16'd0, 16'd0},
			'{-16'sd1, -16'sd1, 1'b0, 16'd0, 16'd0},
			'{16'sd1, -16'sd1, 1'b0, 16'd0, 16'd0},
			'{16'sd32767, -16'sd1, 1'b0, 16'd0, 16'd0},
			'{16'sd32767, 16'sd1, 1'b0, 16'd0, 16'd0},
			'{-16'sd32768, -16'sd1, 1'b0, 16'd0, 16'd0},
			'{-16'sd32768, 16'sd1, 1'b0, 16'd0, 16'd0},
			'{16'sd3, 16'sd4, 1'b0, 16'd0, 16'd0},
			'{-16'sd5, 16'sd12, 1'b0, 16'd0, 16'd0},
			'{16'sd100, -16'sd1, 1'b0, 16'd0, 16'd0},
			'{16'sd0, 16'sd0, 1'b1, 16'd0, 16'd0}
		};

		repeat (3) @(negedge clk);
		arst_n = 1'b1;
		@(negedge clk);

		foreach (directed[i])
			send_point(directed[i].x, directed[i].y, directed[i].typed,
				directed[i].radius, directed[i].angle);

		for (int n = 0; n < RANDOM_POINTS; n++) begin
			if (n == HOLD_AT)
				long_hold_due = 1'b1;
			if (n == RANDOM_POINTS - QUIET_TAIL)
				quiet_phase = 1'b1;
			// Mostly full-range points, some tiny ones and some that hug an axis.
			mode = $urandom_range(0, 5);
			case (mode)
				0: begin
					rx = random_coord(0);
					ry = random_coord(0);
				end
				1: begin
					rx = random_coord(2);
					ry = random_coord(1);
				end
				2: begin
					rx = random_coord(1);
					ry = random_coord(2);
				end
				default: begin
					rx = random_coord(2);
					ry = random_coord(2);
				end
			endcase
			send_point(rx, ry, 1'b0, '0, '0);
		end
		point_valid = 1'b0;

		while (pending_polar.size() != 0)
			@(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);
		if (mismatches == 0)
			$display("Verification passed");
		else
			$display("Verification failed");
		$finish;
	end

endmodule

[cartesian_to_polar_degrees_unit.f]
rtl/cpd_pkg.sv
rtl/cpd_prep.sv
rtl/cpd_cell.sv
rtl/cpd_post.sv
rtl/cartesian_to_polar_degrees_unit.sv
tb/tb_top.sv
